// File: hw/rtl/rht_pkg.sv
// Shared types and constants for the reference-counted handle table.
// Holds the request and response structs, command and status codes and the sequencer states.
// No dependencies.
package rht_pkg;

	localparam int unsigned CMD_W       = 2;
	localparam int unsigned FD_FLD_W    = 11;
	localparam int unsigned SLOT_FLD_W  = 6;
	localparam int unsigned CNT_W       = 11;
	localparam logic [CNT_W-1:0] CNT_MAX = 11'd2047;

	typedef enum logic [CMD_W-1:0] {
		CMD_OPEN  = 2'd0,
		CMD_CLOSE = 2'd1,
		CMD_DUP   = 2'd2,
		CMD_MAP   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		STS_OK       = 2'd0,
		STS_RANGE    = 2'd1,
		STS_FULL     = 2'd2,
		STS_NOT_OPEN = 2'd3
	} status_t;

	typedef struct packed {
		cmd_t                cmd;
		logic [FD_FLD_W-1:0] fd;
		logic [FD_FLD_W-1:0] target_fd;
	} req_t;

	typedef struct packed {
		status_t               status;
		logic [SLOT_FLD_W-1:0] slot;
		logic                  slot_valid;
		logic                  any_open;
	} rsp_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_OPEN,
		ST_LOOK_FD,
		ST_GOT_FD,
		ST_LOOK_TGT,
		ST_GOT_TGT,
		ST_DN_RD,
		ST_DN_WR,
		ST_UP_RD,
		ST_UP_WR,
		ST_RESP
	} state_t;

endpackage

// File: hw/rtl/rht_ram.sv
// Generic synchronous RAM: one write port, one read port, registered read data.
// No dependencies.
module rht_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: hw/rtl/refcounted_handle_table.sv
// Reference-counted handle table: descriptor map and slot counts in synchronous RAMs.
// Range errors go straight to the response; open maps the lowest free slot or reports a full pool;
// map, a miss or dup onto itself only look up; close unmaps and counts down; dup remaps the target.
// One request at a time: the next can be accepted in the cycle after the response is loaded.
// Reset: the descriptor map is swept to unmapped, one entry per cycle, with no request accepted
// until the sweep ends; the busy mask clears at once. Depends on rht_pkg and rht_ram.
module refcounted_handle_table #(
	parameter int unsigned DESCRIPTORS = 1024,
	parameter int unsigned SLOTS       = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  rht_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output rht_pkg::rsp_t rsp
);

	localparam int unsigned AW     = DESCRIPTORS > 1 ? $clog2(DESCRIPTORS) : 1;
	localparam int unsigned SLOT_W = SLOTS > 1 ? $clog2(SLOTS) : 1;
	localparam int unsigned MAP_W  = $clog2(SLOTS + 1);
	localparam logic [AW-1:0]    FD_LAST   = AW'(DESCRIPTORS - 1);
	localparam logic [MAP_W-1:0] MAP_SLOTS = MAP_W'(SLOTS);

	rht_pkg::state_t state_q, state_d;

	// Request context.
	rht_pkg::cmd_t    cmd_q;
	logic [AW-1:0]    fd_q, tgt_q;
	logic [SLOT_W-1:0] src_slot_q, dn_slot_q;
	rht_pkg::status_t status_q;
	logic             valid_q;
	logic [AW-1:0]    clr_q;
	logic [SLOTS-1:0] busy_q;

	// Lowest free slot, registered from the busy mask.
	logic [SLOT_W-1:0] free_q, free_c;
	logic              free_ok_q, free_ok_c;

	// Memory ports.
	logic              map_we;
	logic [AW-1:0]     map_waddr, map_raddr;
	logic [MAP_W-1:0]  map_wdata, map_rdata;
	logic              cnt_we;
	logic [SLOT_W-1:0] cnt_addr;
	logic [rht_pkg::CNT_W-1:0] cnt_wdata, cnt_rdata, cnt_cur;

	logic              accept, rsp_load, entry_ok;
	logic [SLOT_W-1:0] entry_slot;
	logic              range_err;
	rht_pkg::rsp_t     rsp_q;
	logic              rsp_valid_q;

	rht_ram #(.WIDTH(MAP_W), .DEPTH(DESCRIPTORS)) u_map_ram (
		.clk   (clk),
		.we    (map_we),
		.waddr (map_waddr),
		.wdata (map_wdata),
		.raddr (map_raddr),
		.rdata (map_rdata)
	);

	rht_ram #(.WIDTH(rht_pkg::CNT_W), .DEPTH(SLOTS)) u_cnt_ram (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (cnt_addr),
		.wdata (cnt_wdata),
		.raddr (cnt_addr),
		.rdata (cnt_rdata)
	);

	always_comb begin
		free_c    = '0;
		free_ok_c = 1'b0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!busy_q[i]) begin
				free_c    = SLOT_W'(i);
				free_ok_c = 1'b1;
			end
		end
	end

	assign accept     = req_valid && req_ready;
	assign range_err  = (32'(req.fd) >= DESCRIPTORS) ||
		(req.cmd == rht_pkg::CMD_DUP && 32'(req.target_fd) >= DESCRIPTORS);
	assign entry_ok   = (map_rdata != '0) && (map_rdata <= MAP_SLOTS);
	assign entry_slot = SLOT_W'(map_rdata - MAP_W'(1));

	// A slot whose busy bit is clear holds a zero count whatever the RAM says.
	assign cnt_addr = (state_q == rht_pkg::ST_DN_RD || state_q == rht_pkg::ST_DN_WR) ?
		dn_slot_q : src_slot_q;
	assign cnt_cur  = busy_q[cnt_addr] ? cnt_rdata : '0;
	assign rsp_load = (state_q == rht_pkg::ST_RESP) && (!rsp_valid_q || rsp_ready);

	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		map_we    = 1'b0;
		map_waddr = fd_q;
		map_wdata = '0;
		map_raddr = fd_q;
		cnt_we    = 1'b0;
		cnt_wdata = cnt_cur;
		case (state_q)
			rht_pkg::ST_CLEAR: begin
				map_we    = 1'b1;
				map_waddr = clr_q;
				if (clr_q == FD_LAST) begin
					state_d = rht_pkg::ST_IDLE;
				end
			end
			rht_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					if (range_err) begin
						state_d = rht_pkg::ST_RESP;
					end else if (req.cmd == rht_pkg::CMD_OPEN) begin
						state_d = rht_pkg::ST_OPEN;
					end else begin
						state_d = rht_pkg::ST_LOOK_FD;
					end
				end
			end
			rht_pkg::ST_OPEN: begin
				if (free_ok_q) begin
					map_we    = 1'b1;
					map_wdata = MAP_W'(free_q) + MAP_W'(1);
					state_d   = rht_pkg::ST_UP_RD;
				end else begin
					state_d = rht_pkg::ST_RESP;
				end
			end
			rht_pkg::ST_LOOK_FD: begin
				state_d = rht_pkg::ST_GOT_FD;
			end
			rht_pkg::ST_GOT_FD: begin
				if (!entry_ok) begin
					state_d = rht_pkg::ST_RESP;
				end else if (cmd_q == rht_pkg::CMD_CLOSE) begin
					map_we  = 1'b1;
					state_d = rht_pkg::ST_DN_RD;
				end else if (cmd_q == rht_pkg::CMD_DUP && tgt_q != fd_q) begin
					state_d = rht_pkg::ST_LOOK_TGT;
				end else begin
					state_d = rht_pkg::ST_RESP;
				end
			end
			rht_pkg::ST_LOOK_TGT: begin
				map_raddr = tgt_q;
				state_d   = rht_pkg::ST_GOT_TGT;
			end
			rht_pkg::ST_GOT_TGT: begin
				map_we    = 1'b1;
				map_waddr = tgt_q;
				map_wdata = MAP_W'(src_slot_q) + MAP_W'(1);
				state_d   = entry_ok ? rht_pkg::ST_DN_RD : rht_pkg::ST_UP_RD;
			end
			rht_pkg::ST_DN_RD: begin
				state_d = rht_pkg::ST_DN_WR;
			end
			rht_pkg::ST_DN_WR: begin
				cnt_we    = 1'b1;
				cnt_wdata = (cnt_cur != '0) ? cnt_cur - 1'b1 : cnt_cur;
				state_d   = (cmd_q == rht_pkg::CMD_DUP) ? rht_pkg::ST_UP_RD : rht_pkg::ST_RESP;
			end
			rht_pkg::ST_UP_RD: begin
				state_d = rht_pkg::ST_UP_WR;
			end
			rht_pkg::ST_UP_WR: begin
				cnt_we    = 1'b1;
				cnt_wdata = (cnt_cur != rht_pkg::CNT_MAX) ? cnt_cur + 1'b1 : cnt_cur;
				state_d   = rht_pkg::ST_RESP;
			end
			rht_pkg::ST_RESP: begin
				if (rsp_load) begin
					state_d = rht_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = rht_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rht_pkg::ST_CLEAR;
			clr_q       <= '0;
			busy_q      <= '0;
			free_q      <= '0;
			free_ok_q   <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			free_q    <= free_c;
			free_ok_q <= free_ok_c;
			if (state_q == rht_pkg::ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cnt_we) begin
				busy_q[cnt_addr] <= (cnt_wdata != '0);
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q    <= req.cmd;
			fd_q     <= AW'(req.fd);
			tgt_q    <= AW'(req.target_fd);
			status_q <= range_err ? rht_pkg::STS_RANGE : rht_pkg::STS_OK;
			valid_q  <= 1'b0;
		end
		if (state_q == rht_pkg::ST_OPEN) begin
			src_slot_q <= free_q;
			valid_q    <= free_ok_q;
			if (!free_ok_q) begin
				status_q <= rht_pkg::STS_FULL;
			end
		end
		if (state_q == rht_pkg::ST_GOT_FD) begin
			src_slot_q <= entry_slot;
			dn_slot_q  <= entry_slot;
			valid_q    <= entry_ok;
			if (!entry_ok) begin
				status_q <= rht_pkg::STS_NOT_OPEN;
			end
		end
		if (state_q == rht_pkg::ST_GOT_TGT) begin
			dn_slot_q <= entry_slot;
		end
		if (rsp_load) begin
			rsp_q.status     <= status_q;
			rsp_q.slot       <= valid_q ? rht_pkg::SLOT_FLD_W'(src_slot_q) : '0;
			rsp_q.slot_valid <= valid_q;
			rsp_q.any_open   <= |busy_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// The busy mask moves only when a count is written back.
	a_busy_only_on_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != rht_pkg::ST_DN_WR && state_q != rht_pkg::ST_UP_WR) |=> $stable(busy_q))
		else $error("busy mask changed outside a count write");

	a_rsp_from_resp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(state_q) == rht_pkg::ST_RESP)
		else $error("response raised outside the response state");

	a_slot_valid_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.slot_valid) |-> rsp.status == rht_pkg::STS_OK)
		else $error("slot reported with an error status");

	a_no_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp.slot_valid) |-> rsp.slot == '0)
		else $error("slot field nonzero without a slot");

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for refcounted_handle_table: directed table, pool exhaustion,
// weighted random traffic under sender and receiver idling, and a final release of all opens.
// Depends on rht_pkg and the refcounted_handle_table RTL.
module tb;

	localparam int unsigned N_FD      = 1024;
	localparam int unsigned N_SLOT    = 64;
	localparam int unsigned WORK_FDS  = 160;
	localparam int unsigned RAND_PER_PHASE = 175;
	localparam int unsigned LONG_HOLD = 200;

	typedef struct packed {
		rht_pkg::req_t rq;
		logic          typed;
		rht_pkg::rsp_t rs;
	} dir_row_t;

	logic          clk;
	logic          arst_n;
	logic          req_valid;
	logic          req_ready;
	rht_pkg::req_t req;
	logic          rsp_valid;
	logic          rsp_ready;
	rht_pkg::rsp_t rsp;

	// Mirror of the table: per descriptor 0 when unmapped, else slot + 1.
	logic [6:0]                fd_tag [N_FD];
	logic [rht_pkg::CNT_W-1:0] slot_count [N_SLOT];
	logic [N_SLOT-1:0]         busy_slots;
	int unsigned               peak_count;

	rht_pkg::rsp_t expected_rsps[$];
	dir_row_t      dir_rows[$];

	int unsigned n_errors;
	int unsigned n_checked;
	int unsigned n_full;
	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	bit          hold_request;

	refcounted_handle_table #(
		.DESCRIPTORS(N_FD),
		.SLOTS(N_SLOT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	always #5 clk = ~clk;

	function automatic void count_step(input int unsigned s, input bit up);
		if (up && slot_count[s] != rht_pkg::CNT_MAX)
			slot_count[s] = slot_count[s] + 1'b1;
		else if (!up && slot_count[s] != 0)
			slot_count[s] = slot_count[s] - 1'b1;
		busy_slots[s] = (slot_count[s] != 0);
		if (slot_count[s] > peak_count)
			peak_count = slot_count[s];
	endfunction

	// Applies one request to the mirror and returns the response it must produce.
	function automatic rht_pkg::rsp_t table_step(input rht_pkg::req_t r);
		rht_pkg::rsp_t o;
		int unsigned   s;
		int            i;
		logic [6:0]    e;
		logic [6:0]    te;
		o = '0;
		o.status = rht_pkg::STS_OK;
		if (r.fd >= N_FD || (r.cmd == rht_pkg::CMD_DUP && r.target_fd >= N_FD)) begin
			o.status = rht_pkg::STS_RANGE;
		end else if (r.cmd == rht_pkg::CMD_OPEN) begin
			s = N_SLOT;
			for (i = N_SLOT - 1; i >= 0; i--)
				if (slot_count[i] == 0)
					s = i;
			if (s == N_SLOT) begin
				o.status = rht_pkg::STS_FULL;
			end else begin
				fd_tag[r.fd] = 7'(s + 1);
				count_step(s, 1'b1);
				o.slot = 6'(s);
				o.slot_valid = 1'b1;
			end
		end else begin
			e = fd_tag[r.fd];
			if (e == 0) begin
				o.status = rht_pkg::STS_NOT_OPEN;
			end else begin
				s = e - 1;
				o.slot = 6'(s);
				o.slot_valid = 1'b1;
				if (r.cmd == rht_pkg::CMD_CLOSE) begin
					fd_tag[r.fd] = '0;
					count_step(s, 1'b0);
				end else if (r.cmd == rht_pkg::CMD_DUP && r.target_fd != r.fd) begin
					te = fd_tag[r.target_fd];
					if (te != 0)
						count_step(te - 1, 1'b0);
					fd_tag[r.target_fd] = 7'(s + 1);
					count_step(s, 1'b1);
				end
			end
		end
		o.any_open = (busy_slots != 0);
		return o;
	endfunction

	function automatic rht_pkg::req_t mk_req(input rht_pkg::cmd_t c, input int unsigned f,
			input int unsigned t);
		rht_pkg::req_t r;
		r.cmd = c;
		r.fd = 11'(f);
		r.target_fd = 11'(t);
		return r;
	endfunction

	function automatic dir_row_t row(input rht_pkg::cmd_t c, input int unsigned f,
			input int unsigned t, input bit typed, input rht_pkg::status_t st,
			input int unsigned sl, input bit v, input bit a);
		dir_row_t d;
		d.rq = mk_req(c, f, t);
		d.typed = typed;
		d.rs.status = st;
		d.rs.slot = 6'(sl);
		d.rs.slot_valid = v;
		d.rs.any_open = a;
		return d;
	endfunction

	// Draws a descriptor from the working set, mostly one in the wanted mapping state.
	function automatic logic [10:0] pick_fd(input bit want_mapped, input int unsigned pct);
		logic [10:0] f;
		int          k;
		f = 11'($urandom_range(WORK_FDS - 1));
		if ($urandom_range(99) < pct)
			for (k = 0; k < 16 && ((fd_tag[f] != 0) != want_mapped); k++)
				f = 11'($urandom_range(WORK_FDS - 1));
		return f;
	endfunction

	function automatic rht_pkg::req_t pick_request(input int unsigned open_pct);
		rht_pkg::req_t r;
		int unsigned   roll;
		r.target_fd = 11'($urandom_range(WORK_FDS - 1));
		roll = $urandom_range(99);
		if (roll < 8) begin
			r.cmd = rht_pkg::cmd_t'($urandom_range(3));
			r.fd = 11'($urandom_range(2047));
			if ($urandom_range(1))
				r.target_fd = 11'($urandom_range(2047));
		end else if (roll < 8 + open_pct) begin
			r.cmd = rht_pkg::CMD_OPEN;
			r.fd = pick_fd(1'b0, 96);
		end else begin
			r.cmd = rht_pkg::cmd_t'($urandom_range(3, 1));
			r.fd = pick_fd(1'b1, 97);
		end
		return r;
	endfunction

	// Offers one request and records its expected response once it is taken.
	task automatic send_req(input rht_pkg::req_t r, input bit typed = 1'b0,
			input rht_pkg::rsp_t typed_rsp = '0);
		rht_pkg::rsp_t want;
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		do
			@(posedge clk);
		while (!req_ready);
		want = table_step(r);
		if (typed)
			want = typed_rsp;
		if (want.status == rht_pkg::STS_FULL)
			n_full++;
		expected_rsps.push_back(want);
	endtask

	task automatic wait_quiet();
		req_valid <= 1'b0;
		while (expected_rsps.size() != 0)
			@(posedge clk);
	endtask

	// Response side: checks every accepted response and applies back-pressure.
	initial begin
		int            hold_left;
		rht_pkg::rsp_t want;
		hold_left = 0;
		rsp_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_valid && rsp_ready) begin
				if (expected_rsps.size() == 0) begin
					n_errors++;
					$error("response with no request outstanding");
				end else begin
					want = expected_rsps.pop_front();
					n_checked++;
					if (rsp.status !== want.status) begin
						n_errors++;
						$error("status: expected %0d, got %0d", want.status, rsp.status);
					end
					if (rsp.slot !== want.slot) begin
						n_errors++;
						$error("slot: expected %0d, got %0d", want.slot, rsp.slot);
					end
					if (rsp.slot_valid !== want.slot_valid) begin
						n_errors++;
						$error("slot_valid: expected %0d, got %0d", want.slot_valid,
							rsp.slot_valid);
					end
					if (rsp.any_open !== want.any_open) begin
						n_errors++;
						$error("any_open: expected %0d, got %0d", want.any_open, rsp.any_open);
					end
				end
			end
			if (hold_request) begin
				hold_left = LONG_HOLD;
				hold_request = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	initial begin
		#5000000;
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		int unsigned n;
		int unsigned ph;
		int unsigned open_pct;
		int unsigned send_pct [4];
		int unsigned stall_pct [4];
		clk = 1'b0;
		arst_n = 1'b0;
		req_valid <= 1'b0;
		req <= '0;
		n_errors = 0;
		n_checked = 0;
		n_full = 0;
		peak_count = 0;
		hold_request = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		busy_slots = '0;
		foreach (fd_tag[i])
			fd_tag[i] = '0;
		foreach (slot_count[i])
			slot_count[i] = '0;
		send_pct = '{0, 74, 0, 18};
		stall_pct = '{0, 0, 74, 18};

		// Empty table first: misses and out-of-range descriptors, then the first opens, maps, dups and closes.
		dir_rows.push_back(row(rht_pkg::CMD_MAP,   0,    0,    1, rht_pkg::STS_NOT_OPEN,
			0, 0, 0));
		dir_rows.push_back(row(rht_pkg::CMD_CLOSE, 1023, 0,    1, rht_pkg::STS_NOT_OPEN,
			0, 0, 0));
		dir_rows.push_back(row(rht_pkg::CMD_OPEN,  1024, 0,    1, rht_pkg::STS_RANGE,
			0, 0, 0));
		dir_rows.push_back(row(rht_pkg::CMD_OPEN,  2047, 0,    1, rht_pkg::STS_RANGE,
			0, 0, 0));
		dir_rows.push_back(row(rht_pkg::CMD_DUP,   0,    2047, 1, rht_pkg::STS_RANGE,
			0, 0, 0));
		dir_rows.push_back(row(rht_pkg::CMD_DUP,   5,    1024, 1, rht_pkg::STS_RANGE,
			0, 0, 0));
		dir_rows.push_back(row(rht_pkg::CMD_DUP,   0,    0,    1, rht_pkg::STS_NOT_OPEN,
			0, 0, 0));
		dir_rows.push_back(row(rht_pkg::CMD_DUP,   3,    4,    1, rht_pkg::STS_NOT_OPEN,
			0, 0, 0));
		dir_rows.push_back(row(rht_pkg::CMD_CLOSE, 0,    2047, 1, rht_pkg::STS_NOT_OPEN,
			0, 0, 0));
		dir_rows.push_back(row(rht_pkg::CMD_OPEN,  0,    0,    1, rht_pkg::STS_OK,
			0, 1, 1));
		dir_rows.push_back(row(rht_pkg::CMD_OPEN,  1023, 2047, 1, rht_pkg::STS_OK,
			1, 1, 1));
		dir_rows.push_back(row(rht_pkg::CMD_MAP,   1023, 0,    1, rht_pkg::STS_OK,
			1, 1, 1));
		dir_rows.push_back(row(rht_pkg::CMD_DUP,   0,    0,    1, rht_pkg::STS_OK,
			0, 1, 1));
		dir_rows.push_back(row(rht_pkg::CMD_DUP,   0,    1023, 0, rht_pkg::STS_OK, 0, 0, 0));
		dir_rows.push_back(row(rht_pkg::CMD_MAP,   1023, 0,    0, rht_pkg::STS_OK, 0, 0, 0));
		dir_rows.push_back(row(rht_pkg::CMD_OPEN,  7,    0,    0, rht_pkg::STS_OK, 0, 0, 0));
		dir_rows.push_back(row(rht_pkg::CMD_OPEN,  7,    0,    0, rht_pkg::STS_OK, 0, 0, 0));
		dir_rows.push_back(row(rht_pkg::CMD_DUP,   7,    0,    0, rht_pkg::STS_OK, 0, 0, 0));
		dir_rows.push_back(row(rht_pkg::CMD_CLOSE, 0,    0,    0, rht_pkg::STS_OK, 0, 0, 0));
		dir_rows.push_back(row(rht_pkg::CMD_CLOSE, 0,    0,    0, rht_pkg::STS_OK, 0, 0, 0));
		dir_rows.push_back(row(rht_pkg::CMD_MAP,   2047, 0,    0, rht_pkg::STS_OK, 0, 0, 0));
		dir_rows.push_back(row(rht_pkg::CMD_OPEN,  682,  1365, 0, rht_pkg::STS_OK, 0, 0, 0));
		dir_rows.push_back(row(rht_pkg::CMD_CLOSE, 682,  1365, 0, rht_pkg::STS_OK, 0, 0, 0));
		dir_rows.push_back(row(rht_pkg::CMD_CLOSE, 1023, 0,    0, rht_pkg::STS_OK, 0, 0, 0));
		dir_rows.push_back(row(rht_pkg::CMD_CLOSE, 7,    0,    0, rht_pkg::STS_OK, 0, 0, 0));

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i])
			send_req(dir_rows[i].rq, dir_rows[i].typed, dir_rows[i].rs);
		wait_quiet();

		// More opens than slots, so the tail of this run must see a full pool.
		send_idle_pct = 18;
		recv_stall_pct = 18;
		for (n = 200; n < 200 + N_SLOT + 2; n++)
			send_req(mk_req(rht_pkg::CMD_OPEN, n, 0));
		for (n = 200; n < 200 + N_SLOT + 2; n++)
			send_req(mk_req(rht_pkg::CMD_CLOSE, n, 0));
		wait_quiet();

		for (ph = 0; ph < 4; ph++) begin
			send_idle_pct = send_pct[ph];
			recv_stall_pct = stall_pct[ph];
			for (n = 0; n < RAND_PER_PHASE; n++) begin
				if (ph == 0 && n == 60)
					hold_request = 1'b1;
				open_pct = ((n / 40) % 2 == 0) ? 65 : 15;
				send_req(pick_request(open_pct));
			end
			wait_quiet();
		end

		// Release everything still mapped so the table ends empty.
		send_idle_pct = 0;
		recv_stall_pct = 0;
		for (n = 0; n < N_FD; n++)
			if (fd_tag[n] != 0)
				send_req(mk_req(rht_pkg::CMD_CLOSE, n, 0));
		wait_quiet();
		repeat (20) @(posedge clk);

		$display("Checked %0d responses over directed, pool-full, random and release traffic.",
			n_checked);
		$display("Full-pool refusals: %0d; highest slot count reached: %0d.", n_full, peak_count);
		if (n_errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

// File: refcounted_handle_table.f
hw/rtl/rht_pkg.sv
hw/rtl/rht_ram.sv
hw/rtl/refcounted_handle_table.sv
tb/sv/tb.sv
